### rtl/quadratic_root_solver_top_assert.svh
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// same-cycle implication
`define QRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs assertion failed");

// next-cycle implication
`define QRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs assertion failed");

`endif

### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } root_status_t;

  // fraction bits of the result format
  localparam int QFRAC  = 16;
  // result width
  localparam int ROOT_W = 32;

endpackage

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit cell of the square root chain: consumes two radicand bits and
// produces one root bit, registered.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int SW     = 33,
  parameter int RW     = 66,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     in_rad,
  input  logic [SW+1:0]     in_rem,
  input  logic [SW-1:0]     in_root,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_rad,
  output logic [SW+1:0]     out_rem,
  output logic [SW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              valid_r;
  logic [RW-1:0]     rad_r;
  logic [SW+1:0]     rem_r;
  logic [SW-1:0]     root_r;
  logic [SIDE_W-1:0] side_r;

  logic [SW+3:0] cur;
  logic [SW+3:0] trial;
  logic          ge;
  logic [SW+3:0] diff;
  logic [SW+1:0] rem_nxt;
  logic [SW-1:0] root_nxt;

  // trial subtract of (4*root + 1)
  always_comb begin
    cur      = {in_rem, in_rad[RW-1 -: 2]};
    trial    = {2'b00, in_root, 2'b01};
    ge       = (cur >= trial);
    diff     = cur - trial;
    rem_nxt  = ge ? diff[SW+1:0] : cur[SW+1:0];
    root_nxt = {in_root[SW-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= in_rad << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of the restoring divider chain, two lanes sharing one divisor:
// one quotient bit per lane, registered.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int MW     = 34,
  parameter int DMW    = 17,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DMW-1:0]    in_dm,
  input  logic [MW-1:0]     in_num_p,
  input  logic [DMW-1:0]    in_rem_p,
  input  logic [MW-1:0]     in_num_m,
  input  logic [DMW-1:0]    in_rem_m,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DMW-1:0]    out_dm,
  output logic [MW-1:0]     out_num_p,
  output logic [DMW-1:0]    out_rem_p,
  output logic [MW-1:0]     out_num_m,
  output logic [DMW-1:0]    out_rem_m,
  output logic [SIDE_W-1:0] out_side
);

  logic              valid_r;
  logic [DMW-1:0]    dm_r;
  logic [MW-1:0]     num_p_r, num_m_r;
  logic [DMW-1:0]    rem_p_r, rem_m_r;
  logic [SIDE_W-1:0] side_r;

  logic [DMW:0]   t_p, t_m, d_p, d_m;
  logic           ge_p, ge_m;
  logic [MW-1:0]  num_p_nxt, num_m_nxt;
  logic [DMW-1:0] rem_p_nxt, rem_m_nxt;

  // shift in next numerator bit, trial subtract the divisor
  always_comb begin
    t_p       = {in_rem_p, in_num_p[MW-1]};
    t_m       = {in_rem_m, in_num_m[MW-1]};
    ge_p      = (t_p >= {1'b0, in_dm});
    ge_m      = (t_m >= {1'b0, in_dm});
    d_p       = t_p - {1'b0, in_dm};
    d_m       = t_m - {1'b0, in_dm};
    rem_p_nxt = ge_p ? d_p[DMW-1:0] : t_p[DMW-1:0];
    rem_m_nxt = ge_m ? d_m[DMW-1:0] : t_m[DMW-1:0];
    num_p_nxt = {in_num_p[MW-2:0], ge_p};
    num_m_nxt = {in_num_m[MW-2:0], ge_m};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r    <= in_dm;
      num_p_r <= num_p_nxt;
      num_m_r <= num_m_nxt;
      rem_p_r <= rem_p_nxt;
      rem_m_r <= rem_m_nxt;
      side_r  <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_dm    = dm_r;
  assign out_num_p = num_p_r;
  assign out_rem_p = rem_p_r;
  assign out_num_m = num_m_r;
  assign out_rem_m = rem_m_r;
  assign out_side  = side_r;

endmodule

### rtl/quadratic_root_solver_top.sv
// Pipeline from input beat to result:
//   three front stages, COEF_WIDTH+17 square root cells, one numerator stage,
//   COEF_WIDTH+18 divider cells and the output register.
// Throughput: one beat per cycle; the whole chain advances unless the output
//   register holds a beat that is stalled.
// Reset: synchronous, active low; clears all valid bits, no data is cleared.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c in Q16.16 through a chain of square root
// and divider cells.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COEF_WIDTH-1:0]  in_coef_a,
  input  logic [COEF_WIDTH-1:0]  in_coef_b,
  input  logic [COEF_WIDTH-1:0]  in_coef_c,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_root_status,
  output logic [31:0]            out_root_plus,
  output logic [31:0]            out_root_minus,
  output logic                   out_saturated
);

  `include "quadratic_root_solver_top_assert.svh"

  localparam int W    = COEF_WIDTH;
  localparam int DDW  = 2*W + 3;        // signed discriminant
  localparam int SW   = W + 17;         // square root width
  localparam int RW   = 2*SW;           // radicand width
  localparam int BW   = W + 17;         // signed -b * 2^16
  localparam int DNW  = W + 1;          // signed 2a
  localparam int DMW  = W + 1;          // |2a|
  localparam int NW   = W + 19;         // signed numerator
  localparam int MW   = NW - 1;         // numerator magnitude
  localparam int CW   = (MW + 1 > 33) ? MW + 1 : 33;
  localparam int SQS  = 2 + BW + DNW;
  localparam int DVS  = 4;
  localparam int RTW  = qrs_pkg::ROOT_W;

  logic adv;

  // whole chain moves unless the result is held
  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  // ---------------- input register
  logic                v1_r;
  logic signed [W-1:0] a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= in_coef_a;
      b1_r <= in_coef_b;
      c1_r <= in_coef_c;
    end
  end

  // ---------------- products
  logic                  v2_r;
  logic signed [W-1:0]   a2_r, b2_r;
  logic signed [2*W-1:0] pbb_r, pac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      pbb_r <= b1_r * b1_r;
      pac_r <= a1_r * c1_r;
    end
  end

  // ---------------- discriminant and classification
  logic signed [DDW-1:0] disc;
  logic [1:0]            st_c;
  logic signed [BW-1:0]  bsh;
  logic signed [BW-1:0]  base_c;
  logic signed [DNW-1:0] den_c;
  logic [RW-1:0]         rad_c;

  always_comb begin
    disc   = DDW'(pbb_r) - (DDW'(pac_r) <<< 2);
    bsh    = {b2_r[W-1], b2_r, {qrs_pkg::QFRAC{1'b0}}};
    base_c = -bsh;
    den_c  = {a2_r, 1'b0};
    if (a2_r == '0) begin
      st_c = qrs_pkg::ST_AZERO;
    end else if (disc[DDW-1]) begin
      st_c = qrs_pkg::ST_NONE;
    end else if (disc == '0) begin
      st_c = qrs_pkg::ST_ONE;
    end else begin
      st_c = qrs_pkg::ST_TWO;
    end
    rad_c = (st_c == qrs_pkg::ST_TWO)
          ? {1'b0, disc[2*W:0], {RTW{1'b0}}} : '0;
  end

  logic                  v3_r;
  logic [RW-1:0]         rad3_r;
  logic [SQS-1:0]        side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad3_r  <= rad_c;
      side3_r <= {st_c, base_c, den_c};
    end
  end

  // ---------------- square root chain
  logic           sq_v    [SW+1];
  logic [RW-1:0]  sq_rad  [SW+1];
  logic [SW+1:0]  sq_rem  [SW+1];
  logic [SW-1:0]  sq_root [SW+1];
  logic [SQS-1:0] sq_side [SW+1];

  assign sq_v[0]    = v3_r;
  assign sq_rad[0]  = rad3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3_r;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .RW(RW), .SIDE_W(SQS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_v[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // ---------------- numerators and divisor magnitude
  logic [1:0]            st4;
  logic signed [BW-1:0]  base4;
  logic signed [DNW-1:0] den4;
  logic signed [NW-1:0]  s_ext, np, nm, np_mag, nm_mag;
  logic signed [DNW-1:0] dm_c;

  always_comb begin
    {st4, base4, den4} = sq_side[SW];
    s_ext  = {2'b00, sq_root[SW]};
    np     = NW'(base4) + s_ext;
    nm     = NW'(base4) - s_ext;
    np_mag = np[NW-1] ? -np : np;
    nm_mag = nm[NW-1] ? -nm : nm;
    dm_c   = den4[DNW-1] ? -den4 : den4;
  end

  logic            v4_r;
  logic [DMW-1:0]  dm4_r;
  logic [MW-1:0]   np4_r, nm4_r;
  logic [DVS-1:0]  side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm4_r   <= dm_c;
      np4_r   <= np_mag[MW-1:0];
      nm4_r   <= nm_mag[MW-1:0];
      side4_r <= {st4, np[NW-1] ^ den4[DNW-1], nm[NW-1] ^ den4[DNW-1]};
    end
  end

  // ---------------- divider chain
  logic           dv_v    [MW+1];
  logic [DMW-1:0] dv_dm   [MW+1];
  logic [MW-1:0]  dv_np   [MW+1];
  logic [DMW-1:0] dv_rp   [MW+1];
  logic [MW-1:0]  dv_nm   [MW+1];
  logic [DMW-1:0] dv_rm   [MW+1];
  logic [DVS-1:0] dv_side [MW+1];

  assign dv_v[0]    = v4_r;
  assign dv_dm[0]   = dm4_r;
  assign dv_np[0]   = np4_r;
  assign dv_rp[0]   = '0;
  assign dv_nm[0]   = nm4_r;
  assign dv_rm[0]   = '0;
  assign dv_side[0] = side4_r;

  for (genvar j = 0; j < MW; j++) begin : g_div
    qrs_div_cell #(.MW(MW), .DMW(DMW), .SIDE_W(DVS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_v[j]),
      .in_dm     (dv_dm[j]),
      .in_num_p  (dv_np[j]),
      .in_rem_p  (dv_rp[j]),
      .in_num_m  (dv_nm[j]),
      .in_rem_m  (dv_rm[j]),
      .in_side   (dv_side[j]),
      .out_valid (dv_v[j+1]),
      .out_dm    (dv_dm[j+1]),
      .out_num_p (dv_np[j+1]),
      .out_rem_p (dv_rp[j+1]),
      .out_num_m (dv_nm[j+1]),
      .out_rem_m (dv_rm[j+1]),
      .out_side  (dv_side[j+1])
    );
  end

  // ---------------- sign, clamp and status masking
  logic [1:0]           st5;
  logic                 sgn_p, sgn_m;
  logic signed [CW-1:0] qp, qm, qmax, qmin;
  logic                 satp, satm;
  logic [RTW-1:0]       rp, rm;
  logic [RTW-1:0]       rp_nxt, rm_nxt;
  logic                 sat_nxt;

  always_comb begin
    {st5, sgn_p, sgn_m} = dv_side[MW];
    qp   = CW'({1'b0, dv_np[MW]});
    qm   = CW'({1'b0, dv_nm[MW]});
    qp   = sgn_p ? -qp : qp;
    qm   = sgn_m ? -qm : qm;
    qmax = CW'({1'b0, {(RTW-1){1'b1}}});
    qmin = -qmax - CW'(1);
    satp = (qp > qmax) || (qp < qmin);
    satm = (qm > qmax) || (qm < qmin);
    rp   = (qp > qmax) ? qmax[RTW-1:0] : ((qp < qmin) ? qmin[RTW-1:0] : qp[RTW-1:0]);
    rm   = (qm > qmax) ? qmax[RTW-1:0] : ((qm < qmin) ? qmin[RTW-1:0] : qm[RTW-1:0]);
    case (st5)
      qrs_pkg::ST_TWO: begin
        rp_nxt  = rp;
        rm_nxt  = rm;
        sat_nxt = satp | satm;
      end
      qrs_pkg::ST_ONE: begin
        rp_nxt  = rp;
        rm_nxt  = '0;
        sat_nxt = satp;
      end
      default: begin
        rp_nxt  = '0;
        rm_nxt  = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  // ---------------- output register
  logic           out_valid_r;
  logic [1:0]     out_st_r;
  logic [RTW-1:0] out_rp_r, out_rm_r;
  logic           out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_st_r  <= st5;
      out_rp_r  <= rp_nxt;
      out_rm_r  <= rm_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_status = out_st_r;
  assign out_root_plus   = out_rp_r;
  assign out_root_minus  = out_rm_r;
  assign out_saturated   = out_sat_r;

  // ---------------- assertions
  `QRS_ASSERT_IMPL(a_azero_clear, out_valid && out_root_status == qrs_pkg::ST_AZERO,
                   out_root_plus == '0 && out_root_minus == '0 && !out_saturated)
  `QRS_ASSERT_IMPL(a_one_minus_zero, out_valid && out_root_status == qrs_pkg::ST_ONE,
                   out_root_minus == '0)
  `QRS_ASSERT_IMPL(a_sat_at_limit, out_valid && out_saturated,
                   out_root_plus == 32'h7fffffff || out_root_plus == 32'h80000000 ||
                   out_root_minus == 32'h7fffffff || out_root_minus == 32'h80000000)
  `QRS_ASSERT_NEXT(a_frozen_on_stall, out_valid && out_stall,
                   $stable(v3_r) && $stable(v4_r))

endmodule
